// ===== src/med3x3_pkg.sv =====
// med3x3_pkg: pixel and sorted-row types plus compare helpers for the 3x3 median block
// used by med3x3_row_sort, med3x3_select and median_of_window_3x3_top; no dependencies
package med3x3_pkg;

   localparam int PixWidth = 8;

   typedef logic [PixWidth-1:0] pix_type;

   // one window row after sorting, smallest first
   typedef struct packed {
      pix_type lo;
      pix_type mid;
      pix_type hi;
   } trio_type;

   function automatic pix_type min2(input pix_type a, input pix_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pix_type max2(input pix_type a, input pix_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic pix_type med3(input pix_type a, input pix_type b, input pix_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

endpackage

// ===== src/med3x3_row_sort.sv =====
// med3x3_row_sort: sorts one window row of three pixels into a registered trio
// depends on med3x3_pkg
module med3x3_row_sort (
   input  logic                clock,
   input  med3x3_pkg::pix_type pix_a,
   input  med3x3_pkg::pix_type pix_b,
   input  med3x3_pkg::pix_type pix_c,
   output med3x3_pkg::trio_type row_ff
);
   import med3x3_pkg::*;

   pix_type  ab_lo;
   pix_type  ab_hi;
   pix_type  c_hi;
   trio_type row_in;

   // three compare-exchange steps
   always_comb begin
      ab_lo      = min2(pix_a, pix_b);
      ab_hi      = max2(pix_a, pix_b);
      c_hi       = max2(ab_lo, pix_c);
      row_in.lo  = min2(ab_lo, pix_c);
      row_in.mid = min2(ab_hi, c_hi);
      row_in.hi  = max2(ab_hi, c_hi);
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

endmodule

// ===== src/med3x3_select.sv =====
// med3x3_select: picks the median from three sorted rows over two register stages
// depends on med3x3_pkg
module med3x3_select (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid,
   input  med3x3_pkg::trio_type row0,
   input  med3x3_pkg::trio_type row1,
   input  med3x3_pkg::trio_type row2,
   output logic                 valid_ff,
   output med3x3_pkg::pix_type  median_ff
);
   import med3x3_pkg::*;

   logic     cand_valid_ff;
   trio_type cand_ff;
   trio_type cand_in;
   pix_type  median_in;

   // largest of the row minima, median of the row middles, smallest of the row maxima
   always_comb begin
      cand_in.lo  = max2(max2(row0.lo, row1.lo), row2.lo);
      cand_in.mid = med3(row0.mid, row1.mid, row2.mid);
      cand_in.hi  = min2(min2(row0.hi, row1.hi), row2.hi);
      median_in   = med3(cand_ff.lo, cand_ff.mid, cand_ff.hi);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_valid_ff <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         cand_valid_ff <= valid;
         valid_ff      <= cand_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff   <= cand_in;
      median_ff <= median_in;
   end

endmodule

// ===== src/median_of_window_3x3_top.sv =====
// median_of_window_3x3_top: 3x3 median filter kernel, row sort then median select
// depends on med3x3_pkg, med3x3_row_sort and med3x3_select

// Takes one 3x3 window per clock and returns its median (fifth smallest of the nine
// pixels) via row sort, candidate and median registers, with a one-cycle rsp_valid.
// The block is a three-stage pipeline (row sort, candidate select, final median) and
// busy is never raised, so a window may be given on every clock. Results cannot be
// held off: the receiver must take rsp_median_pixel in the cycle rsp_valid is high.
module median_of_window_3x3_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  med3x3_pkg::pix_type req_pix_r0_c0,
   input  med3x3_pkg::pix_type req_pix_r0_c1,
   input  med3x3_pkg::pix_type req_pix_r0_c2,
   input  med3x3_pkg::pix_type req_pix_r1_c0,
   input  med3x3_pkg::pix_type req_pix_r1_c1,
   input  med3x3_pkg::pix_type req_pix_r1_c2,
   input  med3x3_pkg::pix_type req_pix_r2_c0,
   input  med3x3_pkg::pix_type req_pix_r2_c1,
   input  med3x3_pkg::pix_type req_pix_r2_c2,
   output logic                rsp_valid,
   output med3x3_pkg::pix_type rsp_median_pixel
);
   import med3x3_pkg::*;

   logic     sort_valid_ff;
   logic     sort_valid_in;
   trio_type row0_ff;
   trio_type row1_ff;
   trio_type row2_ff;

   assign busy          = 1'b0;
   assign sort_valid_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         sort_valid_ff <= 1'b0;
      end else begin
         sort_valid_ff <= sort_valid_in;
      end
   end

   med3x3_row_sort u_row0 (
      .clock  (clock),
      .pix_a  (req_pix_r0_c0),
      .pix_b  (req_pix_r0_c1),
      .pix_c  (req_pix_r0_c2),
      .row_ff (row0_ff)
   );

   med3x3_row_sort u_row1 (
      .clock  (clock),
      .pix_a  (req_pix_r1_c0),
      .pix_b  (req_pix_r1_c1),
      .pix_c  (req_pix_r1_c2),
      .row_ff (row1_ff)
   );

   med3x3_row_sort u_row2 (
      .clock  (clock),
      .pix_a  (req_pix_r2_c0),
      .pix_b  (req_pix_r2_c1),
      .pix_c  (req_pix_r2_c2),
      .row_ff (row2_ff)
   );

   med3x3_select u_select (
      .clock     (clock),
      .reset     (reset),
      .valid     (sort_valid_ff),
      .row0      (row0_ff),
      .row1      (row1_ff),
      .row2      (row2_ff),
      .valid_ff  (rsp_valid),
      .median_ff (rsp_median_pixel)
   );

   // every accepted window gives a result strobe on rsp_valid
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("accepted window produced no result after three cycles");

   // no result without a matching accepted window
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 3))
      else $error("result strobe without a matching start transfer");

   // the median is always one of the window's own pixels
   a_member : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_median_pixel == $past(req_pix_r0_c0, 3)) ||
         (rsp_median_pixel == $past(req_pix_r0_c1, 3)) ||
         (rsp_median_pixel == $past(req_pix_r0_c2, 3)) ||
         (rsp_median_pixel == $past(req_pix_r1_c0, 3)) ||
         (rsp_median_pixel == $past(req_pix_r1_c1, 3)) ||
         (rsp_median_pixel == $past(req_pix_r1_c2, 3)) ||
         (rsp_median_pixel == $past(req_pix_r2_c0, 3)) ||
         (rsp_median_pixel == $past(req_pix_r2_c1, 3)) ||
         (rsp_median_pixel == $past(req_pix_r2_c2, 3)))
      else $error("median is not one of the window pixels");

endmodule
